// ===== hdl/abst_pkg.sv =====
// shared types, codes and default sizes of the array search tree engine
package abst_pkg;

   localparam int TREE_LEVELS_DEF = 6;
   localparam int KEY_BITS_DEF    = 16;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_MIN    = 2'd2,
      CMD_MAX    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SRCH,
      S_DNODE,
      S_DR,
      S_EXT
   } state_type;

endpackage

// ===== hdl/abst_if.sv =====
// request and response channel interfaces of the array search tree engine
interface abst_req_if;
   logic                         valid;
   logic                         ready;
   logic [abst_pkg::CMD_W-1:0]   command;
   logic [abst_pkg::KEY_W-1:0]   key;

   modport source (output valid, output command, output key, input ready);
   modport sink (input valid, input command, input key, output ready);
endinterface

interface abst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [abst_pkg::STATUS_W-1:0] status;
   logic [abst_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output status, output value, input ready);
   modport sink (input valid, input status, input value, output ready);
endinterface

// ===== hdl/array_bst_table_engine.sv =====
// array binary search tree engine: insert, delete, minimum and maximum over a node store
// The tree lives in one synchronous memory of 2^TREE_LEVELS-1 nodes, each a valid bit and a
// key; node k has its children at 2k+1 and 2k+2. After reset the engine sweeps the memory,
// clearing every node, with req ready low, then takes one request word at a time and
// returns exactly one response word. The single memory read port sets the pace: one node
// is read per cycle while the last step of a command is not stalled, so insert, min and
// max read one node per level visited, and delete, after its search, pulls a successor or
// predecessor key up into the freed node, walking one level per read, until a leaf is freed.
// A finished response waits in an output register; the next request is accepted meanwhile
// and only its last step stalls until that register is free.
module array_bst_table_engine #(
   parameter int TREE_LEVELS = abst_pkg::TREE_LEVELS_DEF,
   parameter int KEY_BITS    = abst_pkg::KEY_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   abst_req_if.sink   req_chan,
   abst_rsp_if.source rsp_chan
);

   localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
   localparam int IDX_W      = TREE_LEVELS;
   localparam int CW         = IDX_W + 1;
   localparam int KW         = (KEY_BITS < abst_pkg::KEY_W) ? KEY_BITS : abst_pkg::KEY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
   localparam logic [CW-1:0]    NODES_CW = CW'(NODE_COUNT);

   abst_pkg::state_type  state_ff, state_in;
   abst_pkg::cmd_type    cmd_ff, cmd_in;
   logic [KW-1:0]        key_ff, key_in;
   logic [IDX_W-1:0]     cand_ff, cand_in;
   logic [IDX_W-1:0]     node_ff, node_in;
   logic [IDX_W-1:0]     ext_ff, ext_in;
   logic [KW-1:0]        ek_ff, ek_in;
   logic                 dir_ff, dir_in;
   logic                 first_ff, first_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   abst_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [abst_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                 rd_en, wr_en, ram_rd, ram_wr;
   logic [IDX_W-1:0]     rd_addr, wr_addr;
   logic [KW:0]          wr_data, rd_data;
   logic                 rd_valid;
   logic [KW-1:0]        rd_key;

   logic                 accept, go, fin;
   abst_pkg::status_type fin_status;
   logic [KW-1:0]        fin_value;
   logic                 do_finish;
   logic [IDX_W-1:0]     finish_src;
   logic [KW-1:0]        finish_key;

   logic                 key_gt, key_eq, is_del;
   logic [CW-1:0]        srch_child, walk_child, left_w, right_w;
   logic                 srch_in_range, walk_in_range, node_is_leaf;

   abst_node_ram #(
      .ADDR_W (IDX_W),
      .DEPTH  (NODE_COUNT),
      .DATA_W (KW + 1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_valid = rd_data[KW];
   assign rd_key   = rd_data[KW-1:0];
   assign key_gt   = key_ff > rd_key;
   assign key_eq   = key_ff == rd_key;
   assign is_del   = cmd_ff == abst_pkg::CMD_DELETE;

   assign srch_child    = {cand_ff, 1'b0} + CW'(1) + CW'(key_gt);
   assign walk_child    = {cand_ff, 1'b0} + CW'(1) + CW'(dir_ff);
   assign left_w        = {node_ff, 1'b0} + CW'(1);
   assign right_w       = {node_ff, 1'b0} + CW'(2);
   assign srch_in_range = srch_child < NODES_CW;
   assign walk_in_range = walk_child < NODES_CW;
   assign node_is_leaf  = left_w >= NODES_CW;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = state_ff == abst_pkg::S_IDLE;

   // last step of a command holds while the previous response is still unread
   assign go     = !fin || !rsp_valid_ff || rsp_chan.ready;
   assign ram_rd = rd_en && go;
   assign ram_wr = wr_en && go;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abst_pkg::S_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = abst_pkg::S_IDLE;
            end
         end
         abst_pkg::S_IDLE: begin
            if (accept) begin
               case (abst_pkg::cmd_type'(req_chan.command))
                  abst_pkg::CMD_INSERT, abst_pkg::CMD_DELETE: state_in = abst_pkg::S_SRCH;
                  default: state_in = abst_pkg::S_EXT;
               endcase
            end
         end
         abst_pkg::S_SRCH: begin
            if (rd_valid && key_eq && is_del) begin
               state_in = abst_pkg::S_DNODE;
            end else if (!rd_valid || key_eq || !srch_in_range) begin
               state_in = abst_pkg::S_IDLE;
            end
         end
         abst_pkg::S_DNODE: begin
            state_in = node_is_leaf ? abst_pkg::S_IDLE : abst_pkg::S_DR;
         end
         abst_pkg::S_DR: begin
            state_in = abst_pkg::S_EXT;
         end
         abst_pkg::S_EXT: begin
            if (rd_valid) begin
               if (!walk_in_range) begin
                  state_in = is_del ? abst_pkg::S_DNODE : abst_pkg::S_IDLE;
               end
            end else if (first_ff) begin
               state_in = abst_pkg::S_IDLE;
            end else begin
               state_in = is_del ? abst_pkg::S_DNODE : abst_pkg::S_IDLE;
            end
         end
         default: state_in = abst_pkg::S_IDLE;
      endcase
   end

   // memory accesses, walk registers and results
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      cand_in    = cand_ff;
      node_in    = node_ff;
      ext_in     = ext_ff;
      ek_in      = ek_ff;
      dir_in     = dir_ff;
      first_in   = first_ff;
      clr_in     = clr_ff;
      rd_en      = 1'b0;
      rd_addr    = cand_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = '0;
      fin        = 1'b0;
      fin_status = abst_pkg::ST_OK;
      fin_value  = '0;
      do_finish  = 1'b0;
      finish_src = cand_ff;
      finish_key = rd_key;
      case (state_ff)
         abst_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         abst_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in   = abst_pkg::cmd_type'(req_chan.command);
               key_in   = req_chan.key[KW-1:0];
               cand_in  = '0;
               first_in = 1'b1;
               dir_in   = abst_pkg::cmd_type'(req_chan.command) == abst_pkg::CMD_MAX;
               rd_en    = 1'b1;
               rd_addr  = '0;
            end
         end
         abst_pkg::S_SRCH: begin
            if (!rd_valid) begin
               fin = 1'b1;
               if (is_del) begin
                  fin_status = abst_pkg::ST_NOTFOUND;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = cand_ff;
                  wr_data = {1'b1, key_ff};
               end
            end else if (key_eq) begin
               if (is_del) begin
                  node_in = cand_ff;
               end else begin
                  fin        = 1'b1;
                  fin_status = abst_pkg::ST_DUP;
               end
            end else if (!srch_in_range) begin
               fin        = 1'b1;
               fin_status = is_del ? abst_pkg::ST_NOTFOUND : abst_pkg::ST_FULL;
            end else begin
               cand_in = srch_child[IDX_W-1:0];
               rd_en   = 1'b1;
               rd_addr = srch_child[IDX_W-1:0];
            end
         end
         abst_pkg::S_DNODE: begin
            if (node_is_leaf) begin
               wr_en = 1'b1;
               fin   = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = right_w[IDX_W-1:0];
            end
         end
         abst_pkg::S_DR: begin
            rd_en = 1'b1;
            if (rd_valid) begin
               // right subtree present: successor is its leftmost node
               cand_in  = right_w[IDX_W-1:0];
               rd_addr  = right_w[IDX_W-1:0];
               dir_in   = 1'b0;
               first_in = 1'b0;
            end else begin
               // left child may be empty too, then the node is a leaf
               cand_in  = left_w[IDX_W-1:0];
               rd_addr  = left_w[IDX_W-1:0];
               dir_in   = 1'b1;
               first_in = 1'b1;
            end
         end
         abst_pkg::S_EXT: begin
            if (rd_valid) begin
               ext_in   = cand_ff;
               ek_in    = rd_key;
               first_in = 1'b0;
               if (walk_in_range) begin
                  cand_in = walk_child[IDX_W-1:0];
                  rd_en   = 1'b1;
                  rd_addr = walk_child[IDX_W-1:0];
               end else begin
                  do_finish  = 1'b1;
                  finish_src = cand_ff;
                  finish_key = rd_key;
               end
            end else if (first_ff) begin
               fin = 1'b1;
               if (is_del) begin
                  wr_en = 1'b1;
               end else begin
                  fin_status = abst_pkg::ST_EMPTY;
               end
            end else begin
               do_finish  = 1'b1;
               finish_src = ext_ff;
               finish_key = ek_ff;
            end
         end
         default: begin
         end
      endcase
      if (do_finish) begin
         if (is_del) begin
            // pull the found key up, then remove it from below
            wr_en   = 1'b1;
            wr_data = {1'b1, finish_key};
            node_in = finish_src;
         end else begin
            fin       = 1'b1;
            fin_value = finish_key;
         end
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (fin && go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_value_in  = abst_pkg::VALUE_W'(fin_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abst_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            state_ff <= state_in;
            clr_ff   <= clr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      if (go) begin
         cmd_ff   <= cmd_in;
         key_ff   <= key_in;
         cand_ff  <= cand_in;
         node_ff  <= node_in;
         ext_ff   <= ext_in;
         ek_ff    <= ek_in;
         dir_ff   <= dir_in;
         first_ff <= first_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.value  = rsp_value_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != abst_pkg::S_IDLE)
      else $error("engine idle right after taking a request");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == abst_pkg::S_IDLE |-> !ram_wr)
      else $error("node store written while idle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (fin && !go) |=> state_ff == $past(state_ff) && !$past(ram_wr))
      else $error("finishing step moved while response register busy");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != abst_pkg::ST_OK) |-> rsp_value_ff == '0)
      else $error("nonzero value on a failed response");

endmodule

// ===== hdl/abst_node_ram.sv =====
// node store: one write port, one read port with registered read data
module abst_node_ram #(
   parameter int ADDR_W = abst_pkg::TREE_LEVELS_DEF,
   parameter int DEPTH  = (1 << abst_pkg::TREE_LEVELS_DEF) - 1,
   parameter int DATA_W = abst_pkg::KEY_BITS_DEF + 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/tb_array_bst_table_engine.sv =====
// self-checking testbench of the array binary search tree engine
module tb_array_bst_table_engine;

   localparam int TREE_LEVELS = abst_pkg::TREE_LEVELS_DEF;
   localparam int KEY_BITS    = abst_pkg::KEY_BITS_DEF;
   localparam int NODES       = (1 << TREE_LEVELS) - 1;
   localparam logic [abst_pkg::KEY_W-1:0] KEY_MASK =
      abst_pkg::KEY_W'((64'd1 << KEY_BITS) - 1);
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      abst_pkg::cmd_type          command;
      logic [abst_pkg::KEY_W-1:0] key;
      bit                         wait_idle;
   } tree_cmd_type;

   typedef struct {
      abst_pkg::status_type         status;
      logic [abst_pkg::VALUE_W-1:0] value;
   } tree_result_type;

   logic clock;
   logic reset;

   abst_req_if req_chan();
   abst_rsp_if rsp_chan();

   array_bst_table_engine #(
      .TREE_LEVELS(TREE_LEVELS),
      .KEY_BITS(KEY_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // shadow copy of the node store
   logic [abst_pkg::KEY_W-1:0] shadow_key [NODES];
   bit                         shadow_used [NODES];

   tree_cmd_type    cmd_q[$];
   tree_result_type result_q[$];
   bit              tracked [logic [abst_pkg::KEY_W-1:0]];

   logic req_accepted;
   int   send_burst;
   int   send_gap;
   int   rx_cycle;
   int   rx_mode;
   int   hold_left;
   bit   hold_done;
   int   results_seen;
   int   idle_cycles;
   int   mismatches;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit slot_taken(int k);
      return k < NODES && shadow_used[k];
   endfunction

   // follow left (dir 0) or right (dir 1) children down to the last filled slot
   function automatic int deepest_child(int k, int dir);
      while (slot_taken(2 * k + 1 + dir))
         k = 2 * k + 1 + dir;
      return k;
   endfunction

   function automatic tree_result_type apply_command(abst_pkg::cmd_type c,
                                                     logic [abst_pkg::KEY_W-1:0] raw);
      tree_result_type            res;
      logic [abst_pkg::KEY_W-1:0] key;
      int                         k;
      int                         src;
      key = raw & KEY_MASK;
      res.status = abst_pkg::ST_OK;
      res.value = '0;
      k = 0;
      case (c)
         abst_pkg::CMD_INSERT, abst_pkg::CMD_DELETE: begin
            while (slot_taken(k) && shadow_key[k] != key)
               k = (key > shadow_key[k]) ? 2 * k + 2 : 2 * k + 1;
            if (c == abst_pkg::CMD_INSERT) begin
               if (slot_taken(k))
                  res.status = abst_pkg::ST_DUP;
               else if (k >= NODES)
                  res.status = abst_pkg::ST_FULL;
               else begin
                  shadow_key[k] = key;
                  shadow_used[k] = 1'b1;
               end
            end else if (!slot_taken(k)) begin
               res.status = abst_pkg::ST_NOTFOUND;
            end else begin
               // pull up predecessor or successor until a leaf is freed
               while (slot_taken(2 * k + 1) || slot_taken(2 * k + 2)) begin
                  src = slot_taken(2 * k + 2) ? deepest_child(2 * k + 2, 0)
                                              : deepest_child(2 * k + 1, 1);
                  shadow_key[k] = shadow_key[src];
                  k = src;
               end
               shadow_used[k] = 1'b0;
               shadow_key[k] = '0;
            end
         end
         default: begin
            if (!slot_taken(0))
               res.status = abst_pkg::ST_EMPTY;
            else
               res.value = shadow_key[deepest_child(0, (c == abst_pkg::CMD_MAX) ? 1 : 0)];
         end
      endcase
      return res;
   endfunction

   task automatic add_item(abst_pkg::cmd_type c, logic [abst_pkg::KEY_W-1:0] k, bit w);
      tree_cmd_type item;
      item.command = c;
      item.key = k;
      item.wait_idle = w;
      cmd_q.push_back(item);
      if (c == abst_pkg::CMD_INSERT)
         tracked[k] = 1'b1;
   endtask

   // request driver: bursts of words with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_burst <= $urandom_range(1, 24);
         send_gap <= 0;
      end else if (!req_chan.valid || req_accepted) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (cmd_q.size() == 0 || (cmd_q[0].wait_idle && result_q.size() != 0)) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.command <= cmd_q[0].command;
            req_chan.key <= cmd_q[0].key;
            if (send_burst <= 1) begin
               send_burst <= $urandom_range(1, 24);
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               send_burst <= send_burst - 1;
            end
         end
      end
   end

   // response ready: a randomly drawn mode that is redrawn at intervals, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_cycle <= 0;
         rx_mode <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (rx_cycle % 8 < 5);
            endcase
         end
      end
   end

   // result check first, then the expectation of a newly taken word
   always @(posedge clock) begin
      tree_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_accepted <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen <= results_seen + 1;
            if (result_q.size() == 0) begin
               $error("unexpected word: status %0d value %0h", rsp_chan.status, rsp_chan.value);
               mismatches++;
            end else begin
               want = result_q.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.value !== want.value) begin
                  $error("value: expected %0h, got %0h", want.value, rsp_chan.value);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            result_q.push_back(apply_command(abst_pkg::cmd_type'(req_chan.command),
                                             req_chan.key));
            void'(cmd_q.pop_front());
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [abst_pkg::KEY_W-1:0] pool[$];
      logic [abst_pkg::KEY_W-1:0] k;
      logic [abst_pkg::KEY_W-1:0] base;
      int                         phase;
      int                         pool_n;
      int                         steps;
      int                         pick;
      bit                         grow;
      abst_pkg::cmd_type          c;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = abst_pkg::CMD_INSERT;
      req_chan.key = '0;
      rsp_chan.ready = 1'b0;
      results_seen = 0;
      mismatches = 0;

      // empty tree, extremes of the key, duplicate, chain past the last level
      add_item(abst_pkg::CMD_MAX, 16'h0000, 1'b0);
      add_item(abst_pkg::CMD_MIN, 16'hFFFF, 1'b0);
      add_item(abst_pkg::CMD_DELETE, 16'h0005, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h8000, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h8000, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h0000, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'hFFFF, 1'b0);
      add_item(abst_pkg::CMD_MIN, 16'h1234, 1'b0);
      add_item(abst_pkg::CMD_MAX, 16'h4321, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h9000, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h9100, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h9200, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h9300, 1'b0);
      add_item(abst_pkg::CMD_INSERT, 16'h9400, 1'b0);
      add_item(abst_pkg::CMD_DELETE, 16'h1234, 1'b0);
      // leaf, then the root with only a right subtree, then a node with only a left subtree
      add_item(abst_pkg::CMD_DELETE, 16'h0000, 1'b0);
      add_item(abst_pkg::CMD_DELETE, 16'h8000, 1'b0);
      add_item(abst_pkg::CMD_DELETE, 16'hFFFF, 1'b0);
      add_item(abst_pkg::CMD_MIN, 16'h0000, 1'b0);
      add_item(abst_pkg::CMD_MAX, 16'h0000, 1'b0);

      phase = 0;
      while (cmd_q.size() < RANDOM_ITEMS) begin
         if (phase % 4 == 3) begin
            // clear every key inserted since the last clear, leaving the tree empty
            foreach (tracked[t])
               add_item(abst_pkg::CMD_DELETE, t, 1'b0);
            tracked.delete();
            add_item(abst_pkg::CMD_MIN, abst_pkg::KEY_W'($urandom), 1'b0);
            add_item(abst_pkg::CMD_MAX, abst_pkg::KEY_W'($urandom), 1'b0);
         end else begin
            grow = (phase % 2 == 0);
            pool.delete();
            pool_n = $urandom_range(4, 48);
            for (int i = 0; i < pool_n; i++)
               pool.push_back(($urandom_range(0, 3) == 0)
                              ? abst_pkg::KEY_W'($urandom_range(0, 63))
                              : abst_pkg::KEY_W'($urandom));
            if ($urandom_range(0, 4) == 0) begin
               // ascending run overflows the depth quickly
               base = abst_pkg::KEY_W'($urandom);
               for (int i = 0; i < 8; i++)
                  add_item(abst_pkg::CMD_INSERT, base + abst_pkg::KEY_W'(3 * i),
                           (i == 0) && (phase % 3 == 1));
            end
            steps = $urandom_range(30, 90);
            for (int i = 0; i < steps; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < (grow ? 60 : 20))
                  c = abst_pkg::CMD_INSERT;
               else if (pick < (grow ? 85 : 80))
                  c = abst_pkg::CMD_DELETE;
               else if (pick < 92)
                  c = abst_pkg::CMD_MIN;
               else
                  c = abst_pkg::CMD_MAX;
               k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                                : abst_pkg::KEY_W'($urandom);
               add_item(c, k, (i == 0) && (phase % 3 == 1));
            end
         end
         phase++;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (cmd_q.size() == 0 && result_q.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
